>>> design/utf8d_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
// Used by the front classifier, the job queue and the result sequencer.
package utf8d_pkg;

  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One job describes every result word that a single input byte causes:
  // vidx invalid words, then the value word if has_val, then invalid words
  // up to cnt in total.
  typedef struct packed {
    logic [2:0]      cnt;
    logic [1:0]      vidx;
    logic            has_val;
    logic            val_bad;
    logic [CP_W-1:0] cp;
    logic            stream_end;
  } job_t;

endpackage

>>> design/utf8d_front.sv
// Front part of the UTF-8 decoder: holds the open sequence and turns each
// accepted byte that causes result words into one job for the queue. Depends on utf8d_pkg.
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_stream_end,
  output logic       push,
  output job_t       job
);

  localparam logic [2:0] LEN_IDLE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000080;
  localparam logic [CP_W-1:0] MIN_LEN3    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_LEN4    = 21'h010000;

  logic [CP_W-1:0] pv_r, pv_nxt;
  logic [2:0]      len_r, len_nxt;
  logic [1:0]      held_r, held_nxt;

  logic            cont;
  logic [2:0]      held_inc;
  logic [CP_W-1:0] ext_val;
  logic [2:0]      pre_cnt, post_cnt;
  logic            has_val, val_bad;
  logic [CP_W-1:0] cp;

  function automatic logic value_bad(input logic [CP_W-1:0] v, input logic [2:0] len);
    logic bad;
    bad = (v > CP_MAX) || ((v >= SURR_LO) && (v <= SURR_HI));
    if ((len == LEN_2) && (v < MIN_LEN2)) bad = 1'b1;
    if ((len == LEN_3) && (v < MIN_LEN3)) bad = 1'b1;
    if ((len == LEN_4) && (v < MIN_LEN4)) bad = 1'b1;
    return bad;
  endfunction

  always_comb begin
    cont     = (in_byte[7:6] == 2'b10);
    held_inc = {1'b0, held_r} + 3'd1;
    ext_val  = {pv_r[CP_W-7:0], in_byte[5:0]};
    pv_nxt   = pv_r;
    len_nxt  = len_r;
    held_nxt = held_r;
    pre_cnt  = 3'd0;
    post_cnt = 3'd0;
    has_val  = 1'b0;
    val_bad  = 1'b0;
    cp       = '0;

    if ((len_r != LEN_IDLE) && cont) begin
      if (held_inc >= len_r) begin
        has_val  = 1'b1;
        cp       = ext_val;
        val_bad  = value_bad(ext_val, len_r);
        pv_nxt   = '0;
        len_nxt  = LEN_IDLE;
        held_nxt = 2'd0;
      end else begin
        pv_nxt   = ext_val;
        held_nxt = held_inc[1:0];
        // A sequence cut short by the end of stream gives one bad word per byte held.
        if (in_stream_end) begin
          post_cnt = held_inc;
          pv_nxt   = '0;
          len_nxt  = LEN_IDLE;
          held_nxt = 2'd0;
        end
      end
    end else begin
      // A broken sequence is dropped first, and the byte is decoded afresh.
      if (len_r != LEN_IDLE) begin
        pre_cnt = {1'b0, held_r};
      end
      pv_nxt   = '0;
      len_nxt  = LEN_IDLE;
      held_nxt = 2'd0;
      if (!in_byte[7]) begin
        has_val = 1'b1;
        cp      = {{(CP_W-8){1'b0}}, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
        pv_nxt   = {{(CP_W-5){1'b0}}, in_byte[4:0]};
        len_nxt  = LEN_2;
        held_nxt = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        pv_nxt   = {{(CP_W-4){1'b0}}, in_byte[3:0]};
        len_nxt  = LEN_3;
        held_nxt = 2'd1;
      end else if (in_byte[7:3] == 5'b11110) begin
        pv_nxt   = {{(CP_W-3){1'b0}}, in_byte[2:0]};
        len_nxt  = LEN_4;
        held_nxt = 2'd1;
      end else begin
        has_val = 1'b1;
        val_bad = 1'b1;
      end
      if (in_stream_end && (len_nxt != LEN_IDLE)) begin
        post_cnt = 3'd1;
        pv_nxt   = '0;
        len_nxt  = LEN_IDLE;
        held_nxt = 2'd0;
      end
    end

    job.cnt        = pre_cnt + {2'b00, has_val} + post_cnt;
    job.vidx       = pre_cnt[1:0];
    job.has_val    = has_val;
    job.val_bad    = val_bad;
    job.cp         = cp;
    job.stream_end = in_stream_end;
  end

  // Bytes that only open or extend a sequence produce no job.
  assign push = accept && (job.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      len_r  <= LEN_IDLE;
      held_r <= 2'd0;
    end else if (accept) begin
      pv_r   <= pv_nxt;
      len_r  <= len_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

>>> design/utf8d_queue.sv
// Short job queue between the decoder front and the result sequencer.
// Depends on utf8d_pkg for the job type and depth.
module utf8d_queue
  import utf8d_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output job_t head
);

  job_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;

  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QUEUE_CW'(1);
      end
    end
  end

endmodule

>>> design/utf8d_back.sv
// Result sequencer of the UTF-8 decoder, uses utf8d_pkg: expands the queue head
// job into result words through an output register, one per cycle unless stalled.
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  job_t            job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_bad_sequence,
  output logic            out_run_last,
  output logic            out_stream_final
);

  logic [1:0]      idx_r;
  logic            out_valid_r;
  logic [CP_W-1:0] cp_r;
  logic            bad_r, last_r, final_r;

  logic            load;
  logic            is_last;
  logic            is_val;
  logic            word_bad;

  assign load     = job_valid && (!out_valid_r || out_ready);
  assign is_last  = ({1'b0, idx_r} == (job.cnt - 3'd1));
  assign is_val   = job.has_val && (idx_r == job.vidx);
  assign word_bad = !is_val || job.val_bad;
  assign pop      = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r    <= word_bad ? '0 : job.cp;
      bad_r   <= word_bad;
      last_r  <= is_last;
      final_r <= is_last && job.stream_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = cp_r;
  assign out_bad_sequence = bad_r;
  assign out_run_last     = last_r;
  assign out_stream_final = final_r;

endmodule

>>> design/utf8_validating_decoder.sv
// Top level of the streaming UTF-8 validating decoder.
// Instantiates utf8d_front, utf8d_queue and utf8d_back; uses utf8d_pkg.
//
//   channel  ports                                       role
//   in_      in_valid/in_ready, in_byte, in_stream_end   one byte per word
//   out_     out_valid/out_ready, out_code_point,        one result per word
//            out_bad_sequence, out_run_last, out_stream_final
//
// A byte is classified in the cycle it is accepted; a byte can be taken every
// cycle while the four-entry job queue has room.
// Results leave from the output register at one word per cycle unless out_ready
// stalls it; a byte causes from 0 to 4 result words.
// Reset is synchronous and clears the open sequence, the queue and the output.
// Stalls on the output fill the queue; in_ready drops only when it is full.
module utf8_validating_decoder
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_stream_end,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_bad_sequence,
  output logic            out_run_last,
  output logic            out_stream_final
);

  logic accept;
  logic push;
  job_t push_job;
  logic pop;
  logic full;
  logic not_empty;
  job_t head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  utf8d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_stream_end (in_stream_end),
    .push          (push),
    .job           (push_job)
  );

  utf8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  utf8d_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (not_empty),
    .job              (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence),
    .out_run_last     (out_run_last),
    .out_stream_final (out_stream_final)
  );

endmodule

>>> dv/utf8_validating_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_validating_decoder: directed byte sequences,
// then random well-formed and broken streams, each result word checked in order.
// Depends on utf8d_pkg and the utf8_validating_decoder RTL.
module utf8_validating_decoder_tb;
  import utf8d_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AT_A    = 60;
  localparam int HOLD_AT_B    = 150;
  localparam int SETTLE       = 20;
  localparam int MAX_WORDS    = 4;
  localparam int MAX_ERR_LINES = 200;

  localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP2    = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP3    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP4    = 21'h010000;

  // Bit 8 carries the end-of-stream mark.
  localparam int DIRECTED_N = 28;
  localparam logic [8:0] DIRECTED [DIRECTED_N] = '{
    9'h000, 9'h07F,                          // ASCII extremes
    9'h0C2, 9'h080,                          // smallest two-byte value
    9'h0EF, 9'h0BF, 9'h0BF,                  // largest three-byte value
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,          // largest scalar value
    9'h0C0, 9'h0AF,                          // overlong form
    9'h0ED, 9'h0A0, 9'h080,                  // surrogate
    9'h0F4, 9'h090, 9'h080, 9'h080,          // above the scalar range
    9'h080, 9'h0FF,                          // stray continuation, bad lead
    9'h0F0, 9'h090, 9'h080, 9'h1C3,          // broken by a lead, then cut at end
    9'h0E2, 9'h182                           // truncated at end of stream
  };

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
    logic       drain;
  } stim_t;

  typedef struct {
    logic [CP_W-1:0] cp;
    logic            bad;
    logic            run_last;
    logic            fin;
  } word_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      in_byte = 8'h00;
  logic            in_stream_end = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [CP_W-1:0] out_code_point;
  logic            out_bad_sequence;
  logic            out_run_last;
  logic            out_stream_final;

  stim_t byte_q[$];
  word_t decoded_q[$];

  // Predictor state: the open sequence.
  logic [CP_W-1:0] acc_cp = '0;
  logic [2:0]      seq_len = '0;
  logic [2:0]      held = '0;

  int bytes_taken = 0;
  int words_due = 0;
  int words_seen = 0;
  int bad_due = 0;
  int streams = 0;
  int errors = 0;
  int err_lines = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;

  utf8_validating_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence),
    .out_run_last     (out_run_last),
    .out_stream_final (out_stream_final)
  );

  always #2 clk = ~clk;

  function automatic logic value_illegal(logic [CP_W-1:0] cp, logic [2:0] len);
    return (cp > MAX_SCALAR) || (cp >= SURR_LO && cp <= SURR_HI) ||
           (len == 3'd2 && cp < MIN_CP2) || (len == 3'd3 && cp < MIN_CP3) ||
           (len == 3'd4 && cp < MIN_CP4);
  endfunction

  function automatic void add_word(ref word_t res[$], input logic [CP_W-1:0] cp,
                                   input logic bad);
    word_t w;
    if (res.size() < MAX_WORDS) begin
      w.cp = bad ? '0 : cp;
      w.bad = bad;
      w.run_last = 1'b0;
      w.fin = 1'b0;
      res.push_back(w);
    end
  endfunction

  // Each byte of an abandoned sequence becomes one invalid word.
  function automatic void drop_held(ref word_t res[$]);
    for (int i = 0; i < held; i++) begin
      add_word(res, '0, 1'b1);
    end
    acc_cp = '0;
    seq_len = '0;
    held = '0;
  endfunction

  // Advances the decoder state by one byte and queues the words it causes.
  function automatic int decode_byte(logic [7:0] b, logic eos);
    word_t res[$];
    logic  consumed;
    consumed = 1'b0;
    if (seq_len != 0) begin
      if (b[7:6] == 2'b10) begin
        acc_cp = {acc_cp[CP_W-7:0], b[5:0]};
        held++;
        consumed = 1'b1;
        if (held >= seq_len) begin
          add_word(res, acc_cp, value_illegal(acc_cp, seq_len));
          acc_cp = '0;
          seq_len = '0;
          held = '0;
        end
      end else begin
        drop_held(res);
      end
    end
    if (!consumed) begin
      if (!b[7]) begin
        add_word(res, CP_W'(b), 1'b0);
      end else if (b[7:5] == 3'b110) begin
        acc_cp = CP_W'(b[4:0]);
        seq_len = 3'd2;
        held = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_cp = CP_W'(b[3:0]);
        seq_len = 3'd3;
        held = 3'd1;
      end else if (b[7:3] == 5'b11110) begin
        acc_cp = CP_W'(b[2:0]);
        seq_len = 3'd4;
        held = 3'd1;
      end else begin
        add_word(res, '0, 1'b1);
      end
    end
    if (eos) begin
      drop_held(res);
      streams++;
    end
    if (res.size() > 0) begin
      res[res.size()-1].run_last = 1'b1;
      res[res.size()-1].fin = eos;
    end
    foreach (res[i]) begin
      decoded_q.push_back(res[i]);
      if (res[i].bad) bad_due++;
    end
    return res.size();
  endfunction

  function automatic void check_field(string name, logic [CP_W-1:0] exp_v,
                                      logic [CP_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (err_lines < MAX_ERR_LINES) begin
        err_lines++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
    end
  endfunction

  function automatic void push_byte(logic [7:0] data, logic last, int gap);
    stim_t s;
    s.data = data;
    s.last = last;
    s.gap = gap;
    s.drain = 1'b0;
    byte_q.push_back(s);
  endfunction

  // Byte driver: offers the next queued byte once the previous gap has run out.
  always @(posedge clk) begin : drive
    logic  offer;
    int    due_now;
    stim_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      due_now = words_due;
      if (in_valid && in_ready) begin
        due_now = words_due + decode_byte(in_byte, in_stream_end);
        words_due <= due_now;
        bytes_taken <= bytes_taken + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() > 0 && !(byte_q[0].drain && due_now != words_seen)) begin
          it = byte_q.pop_front();
          in_byte <= it.data;
          in_stream_end <= it.last;
          gap_left = it.gap;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // Result monitor: checks every word and paces out_ready.
  always @(posedge clk) begin : monitor
    logic  take;
    word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      take = out_ready;
      if (out_valid && out_ready) begin
        words_seen <= words_seen + 1;
        if (decoded_q.size() == 0) begin
          errors++;
          if (err_lines < MAX_ERR_LINES) begin
            err_lines++;
            $display("%0t: unexpected word, expected none, got cp=%h bad=%b", $time,
                     out_code_point, out_bad_sequence);
          end
        end else begin
          exp_w = decoded_q.pop_front();
          check_field("code_point", exp_w.cp, out_code_point);
          check_field("bad_sequence", CP_W'(exp_w.bad), CP_W'(out_bad_sequence));
          check_field("run_last", CP_W'(exp_w.run_last), CP_W'(out_run_last));
          check_field("stream_final", CP_W'(exp_w.fin), CP_W'(out_stream_final));
        end
        // Two long hold-offs let the job queue fill and back up into the input.
        if (words_seen + 1 == HOLD_AT_A || words_seen + 1 == HOLD_AT_B) begin
          hold_left = HOLD_CYCLES;
        end
        stall_left = ((words_seen % 64) < 16) ? 0 : $urandom_range(0, 6);
        take = 1'b0;
      end
      if (!take) begin
        if (hold_left > 0) begin
          hold_left--;
        end else if (stall_left > 0) begin
          stall_left--;
        end else begin
          take = 1'b1;
        end
      end
      out_ready <= take;
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] unit[$];
    logic [7:0] lead;
    int         kind;
    int         len;
    int         n_cont;
    int         total;
    logic       quiet;
    logic       eos;

    foreach (DIRECTED[i]) begin
      push_byte(DIRECTED[i][7:0], DIRECTED[i][8], $urandom_range(0, 6));
    end

    quiet = 1'b0;
    while (byte_q.size() < DIRECTED_N + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      unit.delete();
      kind = $urandom_range(0, 99);
      len = $urandom_range(2, 4);
      case (len)
        2: lead = 8'hC0 | 8'($urandom_range(0, 31));
        3: lead = 8'hE0 | 8'($urandom_range(0, 15));
        default: lead = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
      if (kind < 35) begin
        unit.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 80) begin
        // Complete sequence with random payload.
        unit.push_back(lead);
        repeat (len - 1) unit.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 90) begin
        // Sequence cut short; a following lead or ASCII byte or the end of stream breaks it.
        n_cont = $urandom_range(0, len - 2);
        unit.push_back(lead);
        repeat (n_cont) unit.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end else begin
        unit.push_back(8'($urandom_range(0, 255)));
      end
      eos = ($urandom_range(0, 11) == 0);
      foreach (unit[i]) begin
        push_byte(unit[i], eos && (i == unit.size() - 1), quiet ? 0 : $urandom_range(0, 6));
      end
    end
    // The sender waits for the output to drain at these two points.
    byte_q[DIRECTED_N].drain = 1'b1;
    byte_q[250].drain = 1'b1;
    total = byte_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != total) @(posedge clk);
    while (words_seen != words_due) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (decoded_q.size() != 0) begin
      errors += decoded_q.size();
      $display("%0t: %0d expected words never arrived", $time, decoded_q.size());
    end
    $display("Sent %0d bytes in %0d marked streams; checked %0d result words, %0d invalid.",
             total, streams, words_seen, bad_due);
    $display("Output held off twice for %0d cycles; input paused twice for a full drain.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> utf8_validating_decoder.f
design/utf8d_pkg.sv
design/utf8d_front.sv
design/utf8d_queue.sv
design/utf8d_back.sv
design/utf8_validating_decoder.sv
dv/utf8_validating_decoder_tb.sv
